### rtl/shtl_pkg.sv
// shtl_pkg: shared types and codes for the sorted hash table lookup block
// used by shtl_mem, shtl_ctrl and sorted_hash_table_lookup; no dependencies
`default_nettype none

package shtl_pkg;

  localparam int SHTL_TABLE_ENTRIES = 4096;
  localparam int KEY_W = 64;
  localparam int OFS_W = 32;
  localparam int CMD_W = 2;
  localparam int ST_W  = 3;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;

  typedef enum logic [ST_W-1:0] {
    ST_CLEARED   = 3'd0,
    ST_APPENDED  = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             we;
    logic [KEY_W-1:0] key;
    logic [OFS_W-1:0] ofs;
  } mem_wr_t;

  typedef struct packed {
    status_t          status;
    logic [OFS_W-1:0] offset;
  } res_t;

endpackage

`default_nettype wire

### rtl/sorted_hash_table_lookup.sv
// sorted_hash_table_lookup: sorted key table with append, clear and binary search lookup
// depends on shtl_pkg, shtl_mem and shtl_ctrl
//
// channel  dir  tdata                               tuser
// s_axis   in   [63:0] key, [95:64] entry_offset    [1:0] cmd
// m_axis   out  [31:0] found_offset                 [2:0] status
//
// clear and append go from idle to the done state, which loads the output register and returns to idle
// a lookup does a memory read in the probe state, then a compare, for each probe, at most
//   clog2(TABLE_ENTRIES + 1) probes, and then the done state loads the output register
// rst clears the entry count; table contents are not cleared; s_axis_tready is low in rst
// one output register holds a finished word; the sequencer waits while it is full
`default_nettype none

module sorted_hash_table_lookup #(
  parameter int TABLE_ENTRIES = shtl_pkg::SHTL_TABLE_ENTRIES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [95:0] s_axis_tdata,   // key, entry_offset
  input  wire logic [1:0]  s_axis_tuser,   // cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // found_offset
  output logic [2:0]       m_axis_tuser    // status
);
  import shtl_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  mem_wr_t          mem_wr;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  logic [KEY_W-1:0] rd_key;
  logic [OFS_W-1:0] rd_ofs;
  logic             res_valid;
  logic             res_ready;
  res_t             res;
  res_t             out_res;

  shtl_mem #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_mem (
    .clk    (clk),
    .wr     (mem_wr),
    .wr_addr(wr_addr),
    .rd_addr(rd_addr),
    .rd_key (rd_key),
    .rd_ofs (rd_ofs)
  );

  shtl_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .cmd         (s_axis_tuser),
    .key         (s_axis_tdata[KEY_W-1:0]),
    .entry_offset(s_axis_tdata[KEY_W+OFS_W-1:KEY_W]),
    .mem_wr      (mem_wr),
    .wr_addr     (wr_addr),
    .rd_addr     (rd_addr),
    .rd_key      (rd_key),
    .rd_ofs      (rd_ofs),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = out_res.offset;
  assign m_axis_tuser = out_res.status;

endmodule

`default_nettype wire

### rtl/shtl_mem.sv
// shtl_mem: key and offset storage, one write port and one registered read port
// depends on shtl_pkg
`default_nettype none

module shtl_mem #(
  parameter int TABLE_ENTRIES = shtl_pkg::SHTL_TABLE_ENTRIES,
  localparam int IDX_W = $clog2(TABLE_ENTRIES)
) (
  input  wire logic                     clk,
  input  wire shtl_pkg::mem_wr_t        wr,
  input  wire logic [IDX_W-1:0]         wr_addr,
  input  wire logic [IDX_W-1:0]         rd_addr,
  output logic [shtl_pkg::KEY_W-1:0]    rd_key,
  output logic [shtl_pkg::OFS_W-1:0]    rd_ofs
);
  import shtl_pkg::*;

  logic [KEY_W-1:0] key_mem [TABLE_ENTRIES];
  logic [OFS_W-1:0] ofs_mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      key_mem[wr_addr] <= wr.key;
      ofs_mem[wr_addr] <= wr.ofs;
    end
  end

  always_ff @(posedge clk) begin
    rd_key <= key_mem[rd_addr];
    rd_ofs <= ofs_mem[rd_addr];
  end

endmodule

`default_nettype wire

### rtl/shtl_ctrl.sv
// shtl_ctrl: command sequencer, entry count and binary search probe loop
// depends on shtl_pkg; drives the ports of shtl_mem
`default_nettype none

module shtl_ctrl #(
  parameter int TABLE_ENTRIES = shtl_pkg::SHTL_TABLE_ENTRIES,
  localparam int IDX_W = $clog2(TABLE_ENTRIES),
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [shtl_pkg::CMD_W-1:0] cmd,
  input  wire logic [shtl_pkg::KEY_W-1:0] key,
  input  wire logic [shtl_pkg::OFS_W-1:0] entry_offset,
  output shtl_pkg::mem_wr_t             mem_wr,
  output logic [IDX_W-1:0]              wr_addr,
  output logic [IDX_W-1:0]              rd_addr,
  input  wire logic [shtl_pkg::KEY_W-1:0] rd_key,
  input  wire logic [shtl_pkg::OFS_W-1:0] rd_ofs,
  output logic                          res_valid,
  input  wire logic                     res_ready,
  output shtl_pkg::res_t                res
);
  import shtl_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] lo, lo_next;
  logic [IDX_W-1:0] hi, hi_next;
  logic [IDX_W-1:0] mid, mid_next;
  logic [KEY_W-1:0] sought, sought_next;
  status_t          status, status_next;
  logic [OFS_W-1:0] res_ofs, res_ofs_next;
  logic [IDX_W-1:0] mid_calc;

  assign mid_calc = lo + ((hi - lo) >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    lo      <= lo_next;
    hi      <= hi_next;
    mid     <= mid_next;
    sought  <= sought_next;
    status  <= status_next;
    res_ofs <= res_ofs_next;
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    lo_next      = lo;
    hi_next      = hi;
    mid_next     = mid;
    sought_next  = sought;
    status_next  = status;
    res_ofs_next = res_ofs;
    in_ready     = (state == S_IDLE) && !rst;
    mem_wr.we    = 1'b0;
    mem_wr.key   = key;
    mem_wr.ofs   = entry_offset;
    wr_addr      = count[IDX_W-1:0];
    rd_addr      = mid_calc;
    res_valid    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          res_ofs_next = '0;
          state_next   = S_DONE;
          unique case (cmd)
            CMD_CLEAR: begin
              count_next  = '0;
              status_next = ST_CLEARED;
            end
            CMD_APPEND: begin
              if (count == CNT_W'(TABLE_ENTRIES)) begin
                status_next = ST_FULL;
              end else begin
                mem_wr.we   = 1'b1;
                count_next  = count + 1'b1;
                status_next = ST_APPENDED;
              end
            end
            default: begin
              sought_next = key;
              if (count == '0) begin
                status_next = ST_NOT_FOUND;
              end else begin
                lo_next    = '0;
                hi_next    = IDX_W'(count - 1'b1);
                state_next = S_PROBE;
              end
            end
          endcase
        end
      end
      S_PROBE: begin
        mid_next   = mid_calc;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (rd_key == sought) begin
          status_next  = ST_FOUND;
          res_ofs_next = rd_ofs;
          state_next   = S_DONE;
        end else if (rd_key < sought) begin
          if (mid == hi) begin
            status_next = ST_NOT_FOUND;
            state_next  = S_DONE;
          end else begin
            lo_next    = mid + 1'b1;
            state_next = S_PROBE;
          end
        end else begin
          if (mid == lo) begin
            status_next = ST_NOT_FOUND;
            state_next  = S_DONE;
          end else begin
            hi_next    = mid - 1'b1;
            state_next = S_PROBE;
          end
        end
      end
      S_DONE: begin
        if (res_ready) begin
          res_valid  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign res.status = status;
  assign res.offset = res_ofs;

  a_cmp_after_probe: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> $past(state) == S_PROBE)
    else $error("compare without a preceding probe");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count beyond table size");

  a_probe_window: assert property (@(posedge clk) disable iff (rst)
    state == S_PROBE |-> lo <= hi && CNT_W'(hi) < count)
    else $error("probe window outside loaded entries");

  a_result_to_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> state == S_IDLE)
    else $error("sequencer did not return to idle after result");

  a_found_offset_zero: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && status != ST_FOUND |-> res_ofs == '0)
    else $error("nonzero offset on a result that is not a hit");

endmodule

`default_nettype wire
